// ----- sv/plpm_pkg.sv -----
// shared types and constants for the longest prefix rule matcher
// no dependencies; imported by plpm_cell and path_longest_prefix_rule_match
package plpm_pkg;

	// default sizes of the rule table
	localparam int RULES_DEF        = 16;
	localparam int PREFIX_BYTES_DEF = 64;

	// transaction field widths
	localparam int OP_W    = 2;
	localparam int SLOT_W  = 4;
	localparam int POS_W   = 6;
	localparam int BYTE_W  = 8;
	localparam int PLEN_W  = 6;
	localparam int KIND_W  = 3;
	localparam int CNT_W   = 5;
	localparam int RIDX_W  = 4;
	localparam int MLEN_W  = 6;

	// operation codes
	localparam logic [OP_W-1:0] OP_LOAD_BYTE = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_HDR  = 2'd1;
	localparam logic [OP_W-1:0] OP_PATH      = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE      = 2'd3;

	// register index of the count of rules in use
	localparam logic REG_RULES_USED = 1'b0;

	// special path characters
	localparam logic [BYTE_W-1:0] SLASH_BYTE = 8'h2F;
	localparam logic [BYTE_W-1:0] STAR_BYTE  = 8'h2A;

	// control bundle broadcast from the sequencer to every rule cell
	typedef struct packed {
		logic              wr_byte;
		logic              wr_hdr;
		logic              rd;
		logic              eval;
		logic              last;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  pos;
		logic [BYTE_W-1:0] value;
		logic [PLEN_W-1:0] len;
		logic [KIND_W-1:0] kind;
	} plpm_ctl_t;

endpackage

// ----- sv/path_longest_prefix_rule_match.sv -----
// top level of the longest prefix rule matcher: sequencer, APB register, output register
// depends on plpm_pkg and plpm_cell
//
// Usage: the input channel carries load and query transactions. A load prefix byte
// or load rule header writes one entry of the rule table; a path byte transaction
// streams one byte of the queried path, and the one with last_byte set produces a
// single result transaction (found, rule_index, match_length) on the output channel.
// The user must set the count of rules in use through the APB port while the block is
// idle; the block itself does not enforce this. Steps: a load is captured, then
// written; a path byte is captured, read from the table and compared in every rule
// cell. On the last byte the best rule then travels down the chain of RULES cells,
// one cell per cycle, into the output register. in_stall is high while a
// transaction is in work; one transaction is processed at a time.
// The result waits in the output register while out_stall is high; the block keeps
// taking transactions meanwhile, and only a further result holds off until the
// waiting one has been taken.
// Reset clears the query state, the rule count and the output valid flag, not the rule
// table; the user must write entries before they take part in matching (not enforced).
module path_longest_prefix_rule_match #(
	parameter int RULES        = plpm_pkg::RULES_DEF,
	parameter int PREFIX_BYTES = plpm_pkg::PREFIX_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// apb register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [plpm_pkg::OP_W-1:0]     operation,
	input  logic [plpm_pkg::SLOT_W-1:0]   rule_slot,
	input  logic [plpm_pkg::POS_W-1:0]    byte_pos,
	input  logic [plpm_pkg::BYTE_W-1:0]   byte_value,
	input  logic [plpm_pkg::PLEN_W-1:0]   prefix_length,
	input  logic [plpm_pkg::KIND_W-1:0]   io_kind,
	input  logic                          last_byte,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic [plpm_pkg::RIDX_W-1:0]   rule_index,
	output logic [plpm_pkg::MLEN_W-1:0]   match_length
);
	import plpm_pkg::*;

	localparam int AW    = $clog2(PREFIX_BYTES);
	localparam int PW    = $clog2(PREFIX_BYTES + 1);
	localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
	localparam int CW    = $clog2(RULES + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_EVAL = 4'b0100,
		ST_SCAN = 4'b1000
	} state_t;

	state_t            state_q;
	logic              in_accept;
	logic              cfg_wr;
	logic [CNT_W-1:0]  rules_used_q;
	logic [OP_W-1:0]   op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] value_q;
	logic [PLEN_W-1:0] len_q;
	logic [KIND_W-1:0] kind_q;
	logic              last_q;
	logic [PW-1:0]     path_pos_q;
	logic [KIND_W-1:0] query_kind_q;
	logic [CW-1:0]     scan_cnt_q;
	logic              slot_free;
	logic              load_out;
	logic              out_valid_q;
	logic              found_q;
	logic [RIDX_W-1:0] rule_index_q;
	logic [MLEN_W-1:0] match_length_q;
	plpm_ctl_t         ctl;

	logic              tok_found [RULES+1];
	logic [IDX_W-1:0]  tok_idx   [RULES+1];
	logic [AW-1:0]     tok_len   [RULES+1];

	// apb register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RULES_USED);
	assign prdata = (paddr[2] == REG_RULES_USED) ? 32'(rules_used_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rules_used_q <= '0;
		end else if (cfg_wr) begin
			rules_used_q <= pwdata[CNT_W-1:0];
		end
	end

	// input capture
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q    <= operation;
			slot_q  <= rule_slot;
			pos_q   <= byte_pos;
			value_q <= byte_value;
			len_q   <= prefix_length;
			kind_q  <= io_kind;
			last_q  <= last_byte;
		end
	end

	// control broadcast to the rule cells
	always_comb begin
		ctl         = '0;
		ctl.wr_byte = (state_q == ST_EXEC) && (op_q == OP_LOAD_BYTE);
		ctl.wr_hdr  = (state_q == ST_EXEC) && (op_q == OP_LOAD_HDR);
		ctl.rd      = (state_q == ST_EXEC) && (op_q == OP_PATH);
		ctl.eval    = (state_q == ST_EVAL);
		ctl.last    = last_q;
		ctl.slot    = slot_q;
		ctl.pos     = pos_q;
		ctl.value   = value_q;
		ctl.len     = len_q;
		ctl.kind    = kind_q;
	end

	// result hand-off once the chain has settled
	assign slot_free = !out_valid_q || !out_stall;
	assign load_out  = (state_q == ST_SCAN) && (32'(scan_cnt_q) == RULES) && slot_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			path_pos_q   <= '0;
			query_kind_q <= '0;
			scan_cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (op_q)
						OP_PATH: state_q <= ST_EVAL;
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_EVAL: begin
					if (path_pos_q == '0) begin
						query_kind_q <= kind_q;
					end
					if (32'(path_pos_q) < PREFIX_BYTES) begin
						path_pos_q <= path_pos_q + PW'(1);
					end
					scan_cnt_q <= '0;
					state_q    <= last_q ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					if (32'(scan_cnt_q) != RULES) begin
						scan_cnt_q <= scan_cnt_q + CW'(1);
					end else if (slot_free) begin
						path_pos_q <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// chain of rule cells
	assign tok_found[0] = 1'b0;
	assign tok_idx[0]   = '0;
	assign tok_len[0]   = '0;

	for (genvar i = 0; i < RULES; i++) begin : g_cell
		plpm_cell #(
			.RULES       (RULES),
			.PREFIX_BYTES(PREFIX_BYTES),
			.INDEX       (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.path_pos   (path_pos_q),
			.query_kind (query_kind_q),
			.rules_used (rules_used_q),
			.clear      (load_out),
			.tin_found  (tok_found[i]),
			.tin_idx    (tok_idx[i]),
			.tin_len    (tok_len[i]),
			.tout_found (tok_found[i+1]),
			.tout_idx   (tok_idx[i+1]),
			.tout_len   (tok_len[i+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q        <= tok_found[RULES];
			rule_index_q   <= RIDX_W'(tok_idx[RULES]);
			match_length_q <= MLEN_W'(tok_len[RULES]);
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign rule_index   = rule_index_q;
	assign match_length = match_length_q;

	// a result only appears after a completed scan
	a_result_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_SCAN))
		else $error("result without scan");

	// query state is cleared once a result is taken into the output register
	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (path_pos_q == '0) && (state_q == ST_IDLE))
		else $error("query state not cleared");

	// path position saturates at the table depth
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(path_pos_q) <= PREFIX_BYTES)
		else $error("path position overflow");

	// scan counter never runs past the chain length
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(scan_cnt_q) <= RULES)
		else $error("scan counter overflow");

endmodule

// ----- sv/plpm_cell.sv -----
// one rule cell: prefix bytes, header, match flags and one step of the best-rule chain
// depends on plpm_pkg
module plpm_cell #(
	parameter int RULES        = plpm_pkg::RULES_DEF,
	parameter int PREFIX_BYTES = plpm_pkg::PREFIX_BYTES_DEF,
	parameter int INDEX        = 0,
	localparam int AW    = $clog2(PREFIX_BYTES),
	localparam int PW    = $clog2(PREFIX_BYTES + 1),
	localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  plpm_pkg::plpm_ctl_t          ctl,
	input  logic [PW-1:0]                path_pos,
	input  logic [plpm_pkg::KIND_W-1:0]  query_kind,
	input  logic [plpm_pkg::CNT_W-1:0]   rules_used,
	input  logic                         clear,
	input  logic                         tin_found,
	input  logic [IDX_W-1:0]             tin_idx,
	input  logic [AW-1:0]                tin_len,
	output logic                         tout_found,
	output logic [IDX_W-1:0]             tout_idx,
	output logic [AW-1:0]                tout_len
);
	import plpm_pkg::*;

	logic [BYTE_W-1:0] mem [PREFIX_BYTES];
	logic [BYTE_W-1:0] rd_a_q;
	logic [BYTE_W-1:0] rd_b_q;
	logic [AW-1:0]     len_q;
	logic [KIND_W-1:0] kind_q;
	logic              star_q;
	logic              match_q;
	logic              hit_q;
	logic              sel;
	logic              wr_en;
	logic [PW:0]       p_ext;
	logic [PW:0]       l_ext;
	logic              in_range;
	logic              m_next;
	logic              hit_set;
	logic              cand;
	logic              take;

	assign sel   = (32'(ctl.slot) == INDEX);
	assign wr_en = ctl.wr_byte && sel && (32'(ctl.pos) < PREFIX_BYTES);

	// prefix byte memory, both reads registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(ctl.pos)] <= ctl.value;
		end
		if (ctl.rd) begin
			rd_a_q <= mem[AW'(path_pos)];
			rd_b_q <= mem[len_q - AW'(1)];
		end
	end

	// header and star shadow of the first prefix byte
	always_ff @(posedge clk) begin
		if (ctl.wr_hdr && sel) begin
			if (32'(ctl.len) > PREFIX_BYTES - 1) begin
				len_q <= AW'(PREFIX_BYTES - 1);
			end else begin
				len_q <= AW'(ctl.len);
			end
			kind_q <= ctl.kind;
		end
		if (wr_en && ctl.pos == '0) begin
			star_q <= (ctl.value == STAR_BYTE);
		end
	end

	// per-byte compare against this rule
	always_comb begin
		p_ext    = (PW + 1)'(path_pos);
		l_ext    = (PW + 1)'(len_q);
		in_range = p_ext < l_ext;
		m_next   = match_q && (!in_range || rd_a_q == ctl.value);
		hit_set  = (in_range && (p_ext + (PW + 1)'(1) == l_ext) && m_next
			&& (ctl.last || rd_b_q == SLASH_BYTE))
			|| ((p_ext == l_ext) && match_q && ctl.value == SLASH_BYTE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b1;
			hit_q   <= 1'b0;
		end else if (clear) begin
			match_q <= 1'b1;
			hit_q   <= 1'b0;
		end else if (ctl.eval) begin
			match_q <= m_next;
			if (hit_set) begin
				hit_q <= 1'b1;
			end
		end
	end

	// best-rule chain step: longer wins, earlier cell wins ties
	assign cand = (32'(rules_used) > INDEX) && (kind_q == query_kind)
		&& (hit_q || (len_q == AW'(1) && star_q));
	assign take = cand && (!tin_found || len_q > tin_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tout_found <= 1'b0;
			tout_idx   <= '0;
			tout_len   <= '0;
		end else if (take) begin
			tout_found <= 1'b1;
			tout_idx   <= IDX_W'(INDEX);
			tout_len   <= len_q;
		end else begin
			tout_found <= tin_found;
			tout_idx   <= tin_idx;
			tout_len   <= tin_len;
		end
	end

endmodule
